>>> sv/ambient_light_brightness_control_core_defines.svh
// Assertion macros shared by the ambient light brightness control RTL.
`ifndef AMBIENT_LIGHT_BRIGHTNESS_CONTROL_CORE_DEFINES_SVH
`define AMBIENT_LIGHT_BRIGHTNESS_CONTROL_CORE_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define ALBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define ALBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/albc_pkg.sv
// Package with widths, register indexes and brightness levels of the light control block.
`timescale 1ns / 1ps

package albc_pkg;

  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = 8;
  localparam int SUM_W    = 18;
  localparam int CFG_AW   = 3;
  localparam int WINDOW_DEF = 50;

  // Exact divide by the window: sum * ceil(2^DIV_SHIFT / WINDOW) >> DIV_SHIFT.
  localparam int DIV_SHIFT = 24;
  localparam int RECIP_W   = DIV_SHIFT + 1;

  typedef enum logic [CFG_AW-1:0] {
    CFG_DARK   = 3'd0,
    CFG_DIM    = 3'd1,
    CFG_LOW    = 3'd2,
    CFG_MID    = 3'd3,
    CFG_BRIGHT = 3'd4,
    CFG_HIGH   = 3'd5
  } cfg_idx_t;

  localparam logic [SAMPLE_W-1:0] DARK_RST   = 12'd20;
  localparam logic [SAMPLE_W-1:0] DIM_RST    = 12'd30;
  localparam logic [SAMPLE_W-1:0] LOW_RST    = 12'd100;
  localparam logic [SAMPLE_W-1:0] MID_RST    = 12'd400;
  localparam logic [SAMPLE_W-1:0] BRIGHT_RST = 12'd1000;
  localparam logic [SAMPLE_W-1:0] HIGH_RST   = 12'd1500;

  localparam logic [LEVEL_W-1:0] LVL_DARK   = 8'd5;
  localparam logic [LEVEL_W-1:0] LVL_DIM    = 8'd10;
  localparam logic [LEVEL_W-1:0] LVL_LOW    = 8'd20;
  localparam logic [LEVEL_W-1:0] LVL_MID    = 8'd100;
  localparam logic [LEVEL_W-1:0] LVL_BRIGHT = 8'd100;
  localparam logic [LEVEL_W-1:0] LVL_HIGH   = 8'd150;
  localparam logic [LEVEL_W-1:0] LVL_MAX    = 8'd255;

endpackage

>>> sv/ambient_light_brightness_control_core.sv
// Moving-average light filter with a threshold ladder that selects display brightness.
`timescale 1ns / 1ps
`include "ambient_light_brightness_control_core_defines.svh"

// Usage:
// Each request on the in_ channel carries one 12-bit light sample. The block
// keeps the last WINDOW samples in an on-chip memory and a running sum of them,
// and for every sample returns one request on the out_ channel with the
// truncated window mean and the brightness level picked by six limits.
// Throughput: one sample per cycle while out_stall does not hold the pipeline, set
// by the single read-modify-write of the window memory per sample (read at
// acceptance, write when stage 1 moves on; a bypass covers a window of one entry).
// Pipeline: memory read, running sum, reciprocal multiply, ladder/output register.
// The limits are written through cfg_we/cfg_addr/cfg_wdata while the block is
// idle; indexes above five are ignored.
// Reset: rst_n low clears the pipeline, the sum, the slot pointer and the
// per-entry valid bits (an unwritten entry reads as zero) and restores the
// default limits. No clearing pass is needed; samples are taken right away.
// Stall: while out_stall is high the finished result holds and the stages
// behind it keep filling; in_stall rises once the first stage cannot advance.
module ambient_light_brightness_control_core #(
  parameter int WINDOW = albc_pkg::WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [albc_pkg::SAMPLE_W-1:0]       in_light_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [albc_pkg::SAMPLE_W-1:0]       out_window_mean,
  output logic [albc_pkg::LEVEL_W-1:0]        out_brightness_level,
  input  logic                                cfg_we,
  input  logic [albc_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [albc_pkg::SAMPLE_W-1:0]       cfg_wdata
);
  import albc_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << DIV_SHIFT) + WINDOW - 1) / WINDOW);
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW * 4095);

  // Limit registers
  logic [SAMPLE_W-1:0] dark_r, dim_r, low_r, mid_r, bright_r, high_r;

  // Window memory and per-entry valid bits
  logic [SAMPLE_W-1:0] mem [WINDOW];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                vbit_r [WINDOW];

  logic [SLOT_W-1:0]   write_slot_r, write_slot_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;

  // Stage 1: read data returning
  logic                s1_vld_r;
  logic [SLOT_W-1:0]   s1_slot_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic                s1_fwd_r;
  logic [SAMPLE_W-1:0] s1_fwd_data_r;
  logic [SAMPLE_W-1:0] s1_old;

  // Stage 2: new sum; stage 3: product; output register
  logic                s2_vld_r;
  logic [SUM_W-1:0]    s2_sum_r;
  logic                s3_vld_r;
  logic [PROD_W-1:0]   s3_prod_r;
  logic [SAMPLE_W-1:0] s3_mean;
  logic                out_vld_r;
  logic [SAMPLE_W-1:0] out_mean_r;
  logic [LEVEL_W-1:0]  out_level_r;
  logic [LEVEL_W-1:0]  level_nxt;

  logic out_free, s3_free, s2_free, s1_free;
  logic in_acc, s1_mv, s2_mv, s3_mv;

  always_comb begin
    out_free = !out_vld_r || !out_stall;
    s3_free  = !s3_vld_r || out_free;
    s2_free  = !s2_vld_r || s3_free;
    s1_free  = !s1_vld_r || s2_free;
    s3_mv    = s3_vld_r && out_free;
    s2_mv    = s2_vld_r && s3_free;
    s1_mv    = s1_vld_r && s2_free;
    in_acc   = in_valid && s1_free;
  end

  assign in_stall = !s1_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_r   <= DARK_RST;
      dim_r    <= DIM_RST;
      low_r    <= LOW_RST;
      mid_r    <= MID_RST;
      bright_r <= BRIGHT_RST;
      high_r   <= HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_DARK:   dark_r   <= cfg_wdata;
        CFG_DIM:    dim_r    <= cfg_wdata;
        CFG_LOW:    low_r    <= cfg_wdata;
        CFG_MID:    mid_r    <= cfg_wdata;
        CFG_BRIGHT: bright_r <= cfg_wdata;
        CFG_HIGH:   high_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Window memory: read at acceptance, write back when stage 1 moves on.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= mem[write_slot_r];
    end
    if (s1_mv) begin
      mem[s1_slot_r] <= s1_sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        vbit_r[i] <= 1'b0;
      end
    end else if (s1_mv) begin
      vbit_r[s1_slot_r] <= 1'b1;
    end
  end

  always_comb begin
    write_slot_nxt = (write_slot_r == SLOT_LAST) ? '0 : write_slot_r + 1'b1;
    // The memory read misses a write to the same entry in the same cycle.
    if (s1_fwd_r) begin
      s1_old = s1_fwd_data_r;
    end else if (vbit_r[s1_slot_r]) begin
      s1_old = rd_data_r;
    end else begin
      s1_old = '0;
    end
    sum_nxt = sum_r - SUM_W'(s1_old) + SUM_W'(s1_sample_r);
    s3_mean = s3_prod_r[DIV_SHIFT +: SAMPLE_W];
    if (s3_mean < dark_r) begin
      level_nxt = LVL_DARK;
    end else if (s3_mean < dim_r) begin
      level_nxt = LVL_DIM;
    end else if (s3_mean < low_r) begin
      level_nxt = LVL_LOW;
    end else if (s3_mean < mid_r) begin
      level_nxt = LVL_MID;
    end else if (s3_mean < bright_r) begin
      level_nxt = LVL_BRIGHT;
    end else if (s3_mean < high_r) begin
      level_nxt = LVL_HIGH;
    end else begin
      level_nxt = LVL_MAX;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r <= '0;
      sum_r        <= '0;
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      s3_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        write_slot_r <= write_slot_nxt;
      end
      if (s1_mv) begin
        sum_r <= sum_nxt;
      end
      if (s1_free) begin
        s1_vld_r <= in_acc;
      end
      if (s2_free) begin
        s2_vld_r <= s1_mv;
      end
      if (s3_free) begin
        s3_vld_r <= s2_mv;
      end
      if (out_free) begin
        out_vld_r <= s3_mv;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_slot_r     <= write_slot_r;
      s1_sample_r   <= in_light_sample;
      s1_fwd_r      <= s1_vld_r && (s1_slot_r == write_slot_r);
      s1_fwd_data_r <= s1_sample_r;
    end
    if (s1_mv) begin
      s2_sum_r <= sum_nxt;
    end
    if (s2_mv) begin
      s3_prod_r <= PROD_W'(s2_sum_r) * PROD_W'(RECIP);
    end
    if (s3_mv) begin
      out_mean_r  <= s3_mean;
      out_level_r <= level_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_window_mean      = out_mean_r;
  assign out_brightness_level = out_level_r;

  `ALBC_ASSERT_NOW(a_stall_only_when_busy, in_stall, s1_vld_r, "in_stall without a held stage 1")
  `ALBC_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, s1_vld_r, "accepted sample lost")
  `ALBC_ASSERT_NOW(a_slot_in_range, 1'b1, write_slot_r <= SLOT_LAST, "write slot out of range")
  `ALBC_ASSERT_NOW(a_sum_bounded, 1'b1, sum_r <= SUM_MAX, "running sum exceeds window maximum")

endmodule

>>> tb/ambient_light_brightness_control_core_tb.sv
// Self-checking testbench for the moving-average light filter and brightness ladder.
`timescale 1ns / 1ps

module ambient_light_brightness_control_core_tb;
  import albc_pkg::*;

  localparam int WINDOW_LEN = WINDOW_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int BLOCKS = 15;
  localparam int BLOCK_ITEMS = 102;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
  // Indexes the address field can carry but the block does not decode.
  localparam logic [CFG_AW-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] window_mean;
    logic [LEVEL_W-1:0]  brightness_level;
  } light_result_t;

  class brightness_scoreboard;
    logic [SAMPLE_W-1:0] window_q [WINDOW_LEN];
    logic [SUM_W-1:0]    running_sum;
    int unsigned         slot;
    logic [SAMPLE_W-1:0] limit [6];
    light_result_t       result_q [$];
    int                  errors;
    int                  checked;

    function new();
      foreach (window_q[i]) window_q[i] = '0;
      running_sum = '0;
      slot = 0;
      limit[CFG_DARK]   = DARK_RST;
      limit[CFG_DIM]    = DIM_RST;
      limit[CFG_LOW]    = LOW_RST;
      limit[CFG_MID]    = MID_RST;
      limit[CFG_BRIGHT] = BRIGHT_RST;
      limit[CFG_HIGH]   = HIGH_RST;
      errors = 0;
      checked = 0;
    endfunction

    function void set_limit(logic [CFG_AW-1:0] idx, logic [SAMPLE_W-1:0] val);
      if (idx <= CFG_HIGH) limit[idx] = val;
    endfunction

    // The first limit that the mean falls below decides the level.
    function logic [LEVEL_W-1:0] ladder_level(logic [SAMPLE_W-1:0] mean);
      if (mean < limit[CFG_DARK])   return LVL_DARK;
      if (mean < limit[CFG_DIM])    return LVL_DIM;
      if (mean < limit[CFG_LOW])    return LVL_LOW;
      if (mean < limit[CFG_MID])    return LVL_MID;
      if (mean < limit[CFG_BRIGHT]) return LVL_BRIGHT;
      if (mean < limit[CFG_HIGH])   return LVL_HIGH;
      return LVL_MAX;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s);
      logic [SUM_W-1:0] quotient;
      light_result_t    r;
      running_sum = running_sum - SUM_W'(window_q[slot]) + SUM_W'(s);
      window_q[slot] = s;
      slot = (slot == WINDOW_LEN - 1) ? 0 : slot + 1;
      quotient = SUM_W'(running_sum / WINDOW_LEN);
      r.window_mean = quotient[SAMPLE_W-1:0];
      r.brightness_level = ladder_level(r.window_mean);
      result_q.push_back(r);
    endfunction

    function void check_result(logic [SAMPLE_W-1:0] mean, logic [LEVEL_W-1:0] level);
      light_result_t r;
      if (result_q.size() == 0) begin
        $error("unexpected result request: window_mean %0d brightness_level %0d", mean, level);
        errors++;
        return;
      end
      r = result_q.pop_front();
      checked++;
      if (mean !== r.window_mean) begin
        $error("window_mean expected %0d actual %0d", r.window_mean, mean);
        errors++;
      end
      if (level !== r.brightness_level) begin
        $error("brightness_level expected %0d actual %0d", r.brightness_level, level);
        errors++;
      end
    endfunction

    function int pending();
      return result_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_light_sample;
  logic                out_valid;
  logic                out_stall;
  logic [SAMPLE_W-1:0] out_window_mean;
  logic [LEVEL_W-1:0]  out_brightness_level;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [SAMPLE_W-1:0] cfg_wdata;

  brightness_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int idle_cycles = 0;
  int samples_sent;
  int limit_settings;

  ambient_light_brightness_control_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_light_sample      (in_light_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_window_mean      (out_window_mean),
    .out_brightness_level (out_brightness_level),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && sb != null) begin
      sb.check_result(out_window_mean, out_brightness_level);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Watchdog: no request moved for %0d cycles", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_light_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s);
    samples_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] idx, input logic [SAMPLE_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_limit(idx, val);
  endtask

  // Limits are loaded only with nothing in flight.
  task automatic program_limits(input int mode);
    logic [SAMPLE_W-1:0] vals [6];
    logic [SAMPLE_W-1:0] tmp;
    foreach (vals[i]) vals[i] = SAMPLE_W'($urandom_range(0, 4095));
    case (mode)
      0, 3: begin
        for (int i = 0; i < 5; i++) begin
          for (int j = 0; j < 5 - i; j++) begin
            if ((mode == 0) ? (vals[j] > vals[j+1]) : (vals[j] < vals[j+1])) begin
              tmp = vals[j];
              vals[j] = vals[j+1];
              vals[j+1] = tmp;
            end
          end
        end
      end
      1: foreach (vals[i]) vals[i] = '0;
      2: foreach (vals[i]) vals[i] = SAMPLE_MAX;
      5: begin
        vals[CFG_DARK]   = DARK_RST;
        vals[CFG_DIM]    = DIM_RST;
        vals[CFG_LOW]    = LOW_RST;
        vals[CFG_MID]    = MID_RST;
        vals[CFG_BRIGHT] = BRIGHT_RST;
        vals[CFG_HIGH]   = HIGH_RST;
      end
      default: ;
    endcase
    for (int i = 0; i < 6; i++) cfg_write(CFG_AW'(i), vals[i]);
    cfg_write(CFG_SPARE_A, SAMPLE_W'($urandom_range(0, 4095)));
    cfg_write(CFG_SPARE_B, SAMPLE_W'($urandom_range(0, 4095)));
    cfg_we <= 1'b0;
    limit_settings++;
  endtask

  function automatic logic [SAMPLE_W-1:0] make_sample(int mode, int target);
    int v;
    case (mode)
      0: v = target + int'($urandom_range(0, 64)) - 32;
      1: v = int'($urandom_range(0, 4095));
      2: v = $urandom_range(0, 1) ? 4095 : 0;
      3: v = int'($urandom_range(0, 63));
      default: v = target;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_W'(v);
  endfunction

  // Bursts around one level, or of random, extreme or small samples, let the mean settle anywhere in the range.
  task automatic run_block(input int count);
    int sent;
    int burst;
    int mode;
    int target;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(15, 60);
      mode = $urandom_range(0, 4);
      case ($urandom_range(0, 4))
        0: target = 0;
        1: target = 4095;
        default: target = $urandom_range(0, 4095);
      endcase
      for (int i = 0; i < burst && sent < count; i++) begin
        push_sample(make_sample(mode, target));
        sent++;
      end
    end
  endtask

  initial begin
    logic [SAMPLE_W-1:0] warmup [$];
    sb = new();
    samples_sent = 0;
    limit_settings = 0;
    send_idle_pct = 29;
    recv_idle_pct = 49;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_light_sample <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_DARK;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Warm-up with the reset limits: the ramp walks the mean through every rung.
    warmup = {12'd0, 12'd1200, 12'd1300};
    repeat (19) warmup.push_back(SAMPLE_MAX);
    warmup.push_back(12'd1);
    warmup.push_back(12'hAAA);
    warmup.push_back(12'h555);
    foreach (warmup[i]) push_sample(warmup[i]);

    for (int k = 0; k < BLOCKS; k++) begin
      if (k == BLOCKS / 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 29;
      end else if (k == 2 * BLOCKS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_results();
      program_limits(k % 6);
      run_block(BLOCK_ITEMS);
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("Run covered %0d light samples, %0d checked results and %0d limit settings,",
             samples_sent, sb.checked, limit_settings);
    $display("with sorted, reversed, flat and spare-index register writes under three stall mixes.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
